@@ rtl/cfrd_pkg.sv @@
// Shared types and constants for the capture file record deframer.
package cfrd_pkg;

  // Magic words as read in host (little-endian) order
  localparam logic [31:0] MAGIC_US      = 32'ha1b2c3d4;
  localparam logic [31:0] MAGIC_US_SWAP = 32'hd4c3b2a1;
  localparam logic [31:0] MAGIC_NS      = 32'ha1b23c4d;
  localparam logic [31:0] MAGIC_NS_SWAP = 32'h4d3cb2a1;

  // Timestamp scale factors
  localparam logic [29:0] NS_PER_SEC = 30'd1_000_000_000;
  localparam logic [29:0] US_PER_SEC = 30'd1_000_000;

  // Result kinds
  localparam logic [1:0] KIND_FORMAT  = 2'd0;
  localparam logic [1:0] KIND_RECORD  = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;
  localparam logic [1:0] KIND_SUMMARY = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
  localparam logic [2:0] ST_OVER_SNAP = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;

  // Command queue geometry
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Input transaction
  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_t;

  // Output transaction
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic        last_in_packet;
    logic [63:0] time_key;
    logic [63:0] latest_key;
    logic        key_range_valid;
    logic [31:0] byte_length;
    logic [31:0] record_number;
    logic        nanosecond_mode;
    logic [31:0] link_kind;
    logic [2:0]  status;
  } out_t;

  // Command from the parser to the key and range unit
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic        last_in_packet;
    logic [31:0] seconds;
    logic [31:0] fraction;
    logic [31:0] byte_length;
    logic [31:0] record_number;
    logic        nano;
    logic [31:0] link_kind;
    logic [2:0]  status;
    logic        track;
  } cmd_t;

endpackage

@@ rtl/cfrd_front.sv @@
// Byte parser: walks global header, record headers and payload, issues commands.
module cfrd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  cfrd_pkg::in_t in_i,
  input  logic          full_i,
  output logic          push_o,
  output cfrd_pkg::cmd_t cmd_o
);
  import cfrd_pkg::*;

  typedef enum logic [1:0] {
    PH_GLOBAL,
    PH_RECORD,
    PH_PAYLOAD,
    PH_HALT
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [4:0]  pos_q, pos_d;
  logic [63:0] shift_q, shift_d;
  logic        swap_q, swap_d;
  logic        nano_q, nano_d;
  logic [31:0] cap_q, cap_d;
  logic [31:0] link_q, link_d;
  logic [31:0] sec_q, sec_d;
  logic [31:0] frac_q, frac_d;
  logic [31:0] left_q, left_d;
  logic [31:0] count_q, count_d;
  logic [2:0]  err_q, err_d;
  logic        accept;
  logic [31:0] hi;

  function automatic logic [31:0] fix_word(input logic [31:0] w, input logic sw);
    return sw ? {w[7:0], w[15:8], w[23:16], w[31:24]} : w;
  endfunction

  assign accept = in_valid_i && !full_i;
  assign shift_d = {in_i.data_byte, shift_q[63:8]};
  assign hi = shift_d[63:32];

  // Parse one byte per transaction
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    swap_d  = swap_q;
    nano_d  = nano_q;
    cap_d   = cap_q;
    link_d  = link_q;
    sec_d   = sec_q;
    frac_d  = frac_q;
    left_d  = left_q;
    count_d = count_q;
    err_d   = err_q;
    cmd_o   = '0;
    push_o  = 1'b0;
    if (accept) begin
      if (in_i.mode) begin
        // End of stream: report summary, then re-arm
        push_o             = 1'b1;
        cmd_o.kind         = KIND_SUMMARY;
        cmd_o.record_number = count_q;
        cmd_o.status       = err_q;
        if (phase_q == PH_GLOBAL) begin
          cmd_o.status = ST_SHORT;
        end else begin
          if (phase_q == PH_PAYLOAD && left_q != 32'd0) begin
            cmd_o.status = ST_TRUNC;
          end
          cmd_o.byte_length = cap_q;
          cmd_o.nano        = nano_q;
          cmd_o.link_kind   = link_q;
        end
        phase_d = PH_GLOBAL;
        pos_d   = '0;
        swap_d  = 1'b0;
        nano_d  = 1'b0;
        cap_d   = '0;
        link_d  = '0;
        sec_d   = '0;
        frac_d  = '0;
        left_d  = '0;
        count_d = '0;
        err_d   = ST_OK;
      end else begin
        case (phase_q)
          PH_HALT: begin
            // drop bytes until end of stream
          end
          PH_PAYLOAD: begin
            push_o              = 1'b1;
            cmd_o.kind          = KIND_PAYLOAD;
            cmd_o.payload_byte  = in_i.data_byte;
            cmd_o.record_number = count_q;
            left_d = left_q - 32'd1;
            if (left_q == 32'd1) begin
              cmd_o.last_in_packet = 1'b1;
              count_d = count_q + 32'd1;
              phase_d = PH_RECORD;
            end
          end
          PH_GLOBAL: begin
            if (pos_q == 5'd3) begin
              swap_d = 1'b0;
              nano_d = 1'b0;
              err_d  = ST_OK;
              case (hi)
                MAGIC_US:      ;
                MAGIC_US_SWAP: swap_d = 1'b1;
                MAGIC_NS:      nano_d = 1'b1;
                MAGIC_NS_SWAP: begin
                  swap_d = 1'b1;
                  nano_d = 1'b1;
                end
                default:       err_d = ST_BAD_MAGIC;
              endcase
            end
            if (pos_q < 5'd23) begin
              pos_d = pos_q + 5'd1;
            end else begin
              pos_d      = '0;
              push_o     = 1'b1;
              cmd_o.kind = KIND_FORMAT;
              if (err_d != ST_OK) begin
                swap_d       = 1'b0;
                nano_d       = 1'b0;
                phase_d      = PH_HALT;
                cmd_o.status = ST_BAD_MAGIC;
              end else begin
                cap_d             = fix_word(shift_d[31:0], swap_d);
                link_d            = fix_word(hi, swap_d);
                phase_d           = PH_RECORD;
                cmd_o.byte_length = cap_d;
                cmd_o.nano        = nano_d;
                cmd_o.link_kind   = link_d;
              end
            end
          end
          default: begin
            // Record header
            case (pos_q)
              5'd3:    sec_d  = fix_word(hi, swap_q);
              5'd7:    frac_d = fix_word(hi, swap_q);
              5'd11:   left_d = fix_word(hi, swap_q);
              default: ;
            endcase
            if (pos_q < 5'd15) begin
              pos_d = pos_q + 5'd1;
            end else begin
              pos_d               = '0;
              push_o              = 1'b1;
              cmd_o.kind          = KIND_RECORD;
              cmd_o.seconds       = sec_q;
              cmd_o.fraction      = frac_q;
              cmd_o.byte_length   = left_q;
              cmd_o.record_number = count_q;
              cmd_o.nano          = nano_q;
              cmd_o.link_kind     = link_q;
              if (left_q > cap_q) begin
                err_d        = ST_OVER_SNAP;
                phase_d      = PH_HALT;
                cmd_o.status = ST_OVER_SNAP;
              end else begin
                cmd_o.track = 1'b1;
                if (left_q == 32'd0) begin
                  count_d = count_q + 32'd1;
                end else begin
                  phase_d = PH_PAYLOAD;
                end
              end
            end
          end
        endcase
      end
    end
  end

  // Hold parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_GLOBAL;
      pos_q   <= '0;
      shift_q <= '0;
      swap_q  <= 1'b0;
      nano_q  <= 1'b0;
      cap_q   <= '0;
      link_q  <= '0;
      sec_q   <= '0;
      frac_q  <= '0;
      left_q  <= '0;
      count_q <= '0;
      err_q   <= ST_OK;
    end else begin
      if (accept && !in_i.mode &&
          (phase_q == PH_GLOBAL || phase_q == PH_RECORD)) begin
        shift_q <= shift_d;
      end else if (accept && in_i.mode) begin
        shift_q <= '0;
      end
      phase_q <= phase_d;
      pos_q   <= pos_d;
      swap_q  <= swap_d;
      nano_q  <= nano_d;
      cap_q   <= cap_d;
      link_q  <= link_d;
      sec_q   <= sec_d;
      frac_q  <= frac_d;
      left_q  <= left_d;
      count_q <= count_d;
      err_q   <= err_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_RECORD) |-> (pos_q < 5'd16))
    else $error("record header position out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (left_q != 32'd0 && pos_q == 5'd0))
    else $error("payload phase with nothing left");

endmodule

@@ rtl/cfrd_queue.sv @@
// Short command queue between the parser and the key unit.
module cfrd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cfrd_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output cfrd_pkg::cmd_t head_o
);
  import cfrd_pkg::*;

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      cnt_q <= cnt_q + QCNT_W'(push_i) - QCNT_W'(do_pop);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full command queue");

endmodule

@@ rtl/cfrd_back.sv @@
// Key unit: builds time keys, tracks earliest/latest key, drives results.
module cfrd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  cfrd_pkg::cmd_t q_head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output cfrd_pkg::out_t out_o
);
  import cfrd_pkg::*;

  logic        adv;
  logic        s1_valid_q;
  cmd_t        s1_cmd_q;
  logic [61:0] s1_prod_q, prod;
  logic        s2_valid_q;
  cmd_t        s2_cmd_q;
  logic [63:0] s2_key_q;
  logic        out_valid_q;
  out_t        out_q, out_d;
  logic [63:0] first_q, last_q;
  logic        seen_q;
  logic        s2_summary, s2_track;

  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = adv && q_valid_i;
  assign prod  = {30'd0, q_head_i.seconds} *
                 {32'd0, (q_head_i.nano ? NS_PER_SEC : US_PER_SEC)};

  assign s2_summary = s2_valid_q && (s2_cmd_q.kind == KIND_SUMMARY);
  assign s2_track   = s2_valid_q && s2_cmd_q.track;

  // Assemble the result transaction
  always_comb begin
    out_d                 = '0;
    out_d.kind            = s2_cmd_q.kind;
    out_d.payload_byte    = s2_cmd_q.payload_byte;
    out_d.last_in_packet  = s2_cmd_q.last_in_packet;
    out_d.time_key        = s2_key_q;
    out_d.byte_length     = s2_cmd_q.byte_length;
    out_d.record_number   = s2_cmd_q.record_number;
    out_d.nanosecond_mode = s2_cmd_q.nano;
    out_d.link_kind       = s2_cmd_q.link_kind;
    out_d.status          = s2_cmd_q.status;
    if (s2_cmd_q.kind == KIND_SUMMARY) begin
      out_d.time_key        = first_q;
      out_d.latest_key      = last_q;
      out_d.key_range_valid = seen_q;
    end
  end

  // Multiply, add fraction, then register the result
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_cmd_q  <= q_head_i;
      s1_prod_q <= prod;
      s2_cmd_q  <= s1_cmd_q;
      s2_key_q  <= 64'(s1_prod_q) + 64'(s1_cmd_q.fraction);
      out_q     <= out_d;
    end
  end

  // Advance stage valids and track the key range
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      first_q     <= '0;
      last_q      <= '0;
      seen_q      <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= q_valid_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
      if (s2_summary) begin
        first_q <= '0;
        last_q  <= '0;
        seen_q  <= 1'b0;
      end else if (s2_track) begin
        seen_q <= 1'b1;
        if (!seen_q || s2_key_q < first_q) begin
          first_q <= s2_key_q;
        end
        if (!seen_q || s2_key_q > last_q) begin
          last_q <= s2_key_q;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s2_summary) |=> !seen_q)
    else $error("key range not cleared after summary");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q |-> (first_q <= last_q))
    else $error("earliest key above latest key");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind == KIND_SUMMARY && !out_q.key_range_valid)
      |-> (out_q.time_key == 64'd0 && out_q.latest_key == 64'd0))
    else $error("summary without records carries keys");

endmodule

@@ rtl/capture_file_record_deframer.sv @@
// Top level: capture file record deframer, parser and key unit joined by a queue.
// Each command passes from the parser through the queue and the key unit's registers.
// Throughput: one byte per cycle unless stalled, both in the parser and in the
// key unit (multiply, add, output register), which is a three-stage pipeline.
// A four-entry command queue absorbs output stalls; input stalls while it is full.
// Reset clears all parser and range state; the block then waits for a global header.
module capture_file_record_deframer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  cfrd_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output cfrd_pkg::out_t out_o
);
  import cfrd_pkg::*;

  logic push, pop, full, q_valid;
  cmd_t cmd, head;

  assign in_stall_o = full;

  cfrd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_i       (in_i),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  cfrd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (q_valid),
    .head_o  (head)
  );

  cfrd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule
